// ===== rtl/q2e_pkg.sv =====
// shared types, constants and the arctangent table for the quaternion to euler block
// no dependencies; used by every module under rtl
package q2e_pkg;

  // number of cordic micro-rotations per angle, capped at the table length
  localparam int CORDIC_STEPS  = 16;
  localparam int ANG_TABLE_LEN = 24;
  localparam int CORDIC_ITERS  = (CORDIC_STEPS < ANG_TABLE_LEN) ? CORDIC_STEPS : ANG_TABLE_LEN;

  // operand widths
  localparam int QUAT_W = 16;
  localparam int PROD_W = 32;
  localparam int VEC_W  = 35;
  localparam int ARG_W  = 32;
  localparam int ROOT_W = 31;
  localparam int ROT_W  = 44;
  localparam int NORM_W = 40;
  localparam int ACC_W  = 26;
  localparam int ANG_W  = 16;
  localparam int PITCH_W = 15;

  // pipeline depths
  localparam int ISQ_ITERS   = 31;
  localparam int ISQ_LAT     = ISQ_ITERS + 2;
  localparam int NORM_STAGES = 6;
  localparam int ATAN_LAT    = 1 + NORM_STAGES + CORDIC_ITERS + 1;
  localparam int BACK_LAT    = ISQ_LAT + ATAN_LAT;

  // queue between front and back
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  // numeric constants
  localparam int ONE_Q30     = 1073741824;
  localparam int DEG180_FINE = 5898240;
  localparam int ATAN_MAX    = 23040;
  localparam int PITCH_MAX   = 11520;
  localparam int ROUND_HALF  = 128;

  // one request as it travels from front to back
  typedef struct packed {
    logic signed [VEC_W-1:0] roll_num;
    logic signed [VEC_W-1:0] roll_den;
    logic signed [VEC_W-1:0] yaw_num;
    logic signed [VEC_W-1:0] yaw_den;
    logic signed [ARG_W-1:0] pitch_arg;
    logic                    pitch_clamped;
    logic                    pitch_edge;
  } q2e_item_t;

  // queue status seen by the front and the back
  typedef struct packed {
    logic full;
    logic empty;
  } q2e_fifo_stat_t;

  // pitch side flags carried alongside the cordic
  typedef struct packed {
    logic clamped;
    logic edge_hit;
    logic neg;
  } q2e_flags_t;

  // atan(2^-i) in 1/32768 degree, rounded to nearest
  function automatic logic signed [ACC_W-1:0] atan_fine(input int idx);
    logic signed [ACC_W-1:0] val;
    case (idx)
      0:  val = ACC_W'(1474560);
      1:  val = ACC_W'(870484);
      2:  val = ACC_W'(459940);
      3:  val = ACC_W'(233473);
      4:  val = ACC_W'(117189);
      5:  val = ACC_W'(58652);
      6:  val = ACC_W'(29333);
      7:  val = ACC_W'(14667);
      8:  val = ACC_W'(7334);
      9:  val = ACC_W'(3667);
      10: val = ACC_W'(1833);
      11: val = ACC_W'(917);
      12: val = ACC_W'(458);
      13: val = ACC_W'(229);
      14: val = ACC_W'(115);
      15: val = ACC_W'(57);
      16: val = ACC_W'(29);
      17: val = ACC_W'(14);
      18: val = ACC_W'(7);
      19: val = ACC_W'(4);
      20: val = ACC_W'(2);
      21: val = ACC_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

// ===== rtl/q2e_front.sv =====
// front end: takes quaternion requests, forms the products and the atan2/asin operands
// depends on q2e_pkg; pushes finished operands into q2e_fifo
module q2e_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [q2e_pkg::QUAT_W-1:0]   quat_w,
  input  logic signed [q2e_pkg::QUAT_W-1:0]   quat_x,
  input  logic signed [q2e_pkg::QUAT_W-1:0]   quat_y,
  input  logic signed [q2e_pkg::QUAT_W-1:0]   quat_z,
  input  q2e_pkg::q2e_fifo_stat_t             stat,
  output logic                                push,
  output q2e_pkg::q2e_item_t                  item
);

  localparam int PW = q2e_pkg::PROD_W;
  localparam int VW = q2e_pkg::VEC_W;
  localparam logic signed [VW-1:0] ONE_V = VW'(q2e_pkg::ONE_Q30);

  logic s1_valid;
  logic s2_valid;
  logic fen;

  logic signed [PW-1:0] ww, xx, yy, zz, yz, xw, xy, zw, yw, xz;
  logic signed [PW-1:0] ww_next, xx_next, yy_next, zz_next, yz_next;
  logic signed [PW-1:0] xw_next, xy_next, zw_next, yw_next, xz_next;

  logic signed [VW-1:0] a_raw;
  logic signed [VW-1:0] a_clip;
  logic                 clip_hit;
  q2e_pkg::q2e_item_t   item_next;

  // the whole front moves unless its last stage is blocked by a full queue
  assign fen      = !(s2_valid && stat.full);
  assign in_ready = fen;
  assign push     = s2_valid && !stat.full;

  // stage one: the ten products
  assign ww_next = quat_w * quat_w;
  assign xx_next = quat_x * quat_x;
  assign yy_next = quat_y * quat_y;
  assign zz_next = quat_z * quat_z;
  assign yz_next = quat_y * quat_z;
  assign xw_next = quat_x * quat_w;
  assign xy_next = quat_x * quat_y;
  assign zw_next = quat_z * quat_w;
  assign yw_next = quat_y * quat_w;
  assign xz_next = quat_x * quat_z;

  // stage two: operand sums and asin argument clamp
  always_comb begin
    a_raw    = (VW'(yw) - VW'(xz)) <<< 1;
    clip_hit = 1'b0;
    a_clip   = a_raw;
    if (a_raw > ONE_V) begin
      clip_hit = 1'b1;
      a_clip   = ONE_V;
    end else if (a_raw < -ONE_V) begin
      clip_hit = 1'b1;
      a_clip   = -ONE_V;
    end
    item_next.roll_num      = (VW'(yz) + VW'(xw)) <<< 1;
    item_next.roll_den      = VW'(ww) - VW'(xx) - VW'(yy) + VW'(zz);
    item_next.yaw_num       = (VW'(xy) + VW'(zw)) <<< 1;
    item_next.yaw_den       = VW'(ww) + VW'(xx) - VW'(yy) - VW'(zz);
    item_next.pitch_arg     = q2e_pkg::ARG_W'(a_clip);
    item_next.pitch_clamped = clip_hit;
    item_next.pitch_edge    = (a_clip == ONE_V) || (a_clip == -ONE_V);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (fen) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (fen) begin
      ww   <= ww_next;
      xx   <= xx_next;
      yy   <= yy_next;
      zz   <= zz_next;
      yz   <= yz_next;
      xw   <= xw_next;
      xy   <= xy_next;
      zw   <= zw_next;
      yw   <= yw_next;
      xz   <= xz_next;
      item <= item_next;
    end
  end

endmodule

// ===== rtl/q2e_fifo.sv =====
// short queue that decouples the front end from the cordic back end
// depends on q2e_pkg for the request type and depth
module q2e_fifo (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  q2e_pkg::q2e_item_t      push_item,
  input  logic                    pop,
  output q2e_pkg::q2e_item_t      pop_item,
  output q2e_pkg::q2e_fifo_stat_t stat
);

  localparam int AW = q2e_pkg::FIFO_AW;

  q2e_pkg::q2e_item_t mem [0:q2e_pkg::FIFO_DEPTH-1];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;

  assign stat.empty = (count == '0);
  assign stat.full  = (count == (AW+1)'(q2e_pkg::FIFO_DEPTH));
  assign pop_item   = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_item;
  end

`ifndef SYNTH
  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(q2e_pkg::FIFO_DEPTH)) else $error("queue fill beyond depth");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !stat.full) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !stat.empty) else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/q2e_isqrt.sv =====
// pipelined integer square root of 2^60 - a^2, one result bit per stage
// depends on q2e_pkg for widths and depth
module q2e_isqrt (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [q2e_pkg::ARG_W-1:0]  arg,
  output logic [q2e_pkg::ROOT_W-1:0]        root
);

  localparam int N    = q2e_pkg::ISQ_ITERS;
  localparam int SQ_W = 62;
  localparam logic [SQ_W-1:0] ONE_SQ = SQ_W'(1) << 60;

  logic signed [2*q2e_pkg::ARG_W-1:0] prod;
  logic [SQ_W-1:0] sq;
  logic [SQ_W-1:0] rem_q [0:N];
  logic [SQ_W-1:0] res_q [0:N];

  assign prod = arg * arg;

  // square, then the radicand
  always_ff @(posedge clk) begin
    if (en) begin
      sq       <= prod[SQ_W-1:0];
      rem_q[0] <= ONE_SQ - sq;
      res_q[0] <= '0;
    end
  end

  // one restoring step per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2*(N-1-k));
    logic [SQ_W-1:0] trial;
    assign trial = res_q[k] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem_q[k] >= trial) begin
          rem_q[k+1] <= rem_q[k] - trial;
          res_q[k+1] <= (res_q[k] >> 1) + BIT;
        end else begin
          rem_q[k+1] <= rem_q[k];
          res_q[k+1] <= res_q[k] >> 1;
        end
      end
    end
  end

  assign root = res_q[N][q2e_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/q2e_atan2.sv =====
// pipelined atan2: half-turn fold, staged normalise, vectoring cordic, rounding
// depends on q2e_pkg for widths, depths and the arctangent table
module q2e_atan2 (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [q2e_pkg::VEC_W-1:0]  num,
  input  logic signed [q2e_pkg::VEC_W-1:0]  den,
  output logic signed [q2e_pkg::ANG_W-1:0]  angle
);

  localparam int RW = q2e_pkg::ROT_W;
  localparam int MW = q2e_pkg::NORM_W;
  localparam int AW = q2e_pkg::ACC_W;
  localparam int NS = q2e_pkg::NORM_STAGES;
  localparam int NC = q2e_pkg::CORDIC_ITERS;
  localparam int L  = NS + NC;
  localparam logic signed [AW-1:0] HALF_TURN = AW'(q2e_pkg::DEG180_FINE);
  localparam logic signed [AW-1:0] SAT_HI    = AW'(q2e_pkg::ATAN_MAX);
  localparam logic signed [AW-1:0] RND       = AW'(q2e_pkg::ROUND_HALF);

  logic signed [RW-1:0] n_q [0:L];
  logic signed [RW-1:0] d_q [0:L];
  logic signed [AW-1:0] a_q [0:L];
  logic                 z_q [0:L];
  logic [MW-1:0]        m_q [0:NS];

  logic signed [RW-1:0] n_fold, d_fold, n_abs, d_abs;
  logic signed [AW-1:0] a_fold;
  logic signed [AW-1:0] rnd;
  logic signed [AW-1:0] sat;

  // fold a negative denominator by half a turn
  always_comb begin
    n_fold = RW'(num);
    d_fold = RW'(den);
    a_fold = '0;
    if (den < 0) begin
      n_fold = -RW'(num);
      d_fold = -RW'(den);
      a_fold = (num >= 0) ? HALF_TURN : -HALF_TURN;
    end
    n_abs = (n_fold < 0) ? -n_fold : n_fold;
    d_abs = (d_fold < 0) ? -d_fold : d_fold;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_q[0] <= n_fold;
      d_q[0] <= d_fold;
      a_q[0] <= a_fold;
      z_q[0] <= (num == '0) && (den == '0);
      m_q[0] <= (n_abs > d_abs) ? MW'(n_abs) : MW'(d_abs);
    end
  end

  // normalise: shift left by 32, 16, 8, 4, 2, 1 while the top bits stay clear
  for (genvar j = 0; j < NS; j++) begin : g_norm
    localparam int S = 1 << (NS-1-j);
    logic hit;
    assign hit = (m_q[j][MW-1 -: S] == '0);
    always_ff @(posedge clk) begin
      if (en) begin
        n_q[j+1] <= hit ? (n_q[j] <<< S) : n_q[j];
        d_q[j+1] <= hit ? (d_q[j] <<< S) : d_q[j];
        m_q[j+1] <= hit ? (m_q[j] << S) : m_q[j];
        a_q[j+1] <= a_q[j];
        z_q[j+1] <= z_q[j];
      end
    end
  end

  // vectoring micro-rotations
  for (genvar i = 0; i < NC; i++) begin : g_rot
    localparam logic signed [AW-1:0] STEP = q2e_pkg::atan_fine(i);
    logic signed [RW-1:0] dxs, dys;
    assign dxs = n_q[NS+i] >>> i;
    assign dys = d_q[NS+i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        if (n_q[NS+i] >= 0) begin
          d_q[NS+i+1] <= d_q[NS+i] + dxs;
          n_q[NS+i+1] <= n_q[NS+i] - dys;
          a_q[NS+i+1] <= a_q[NS+i] + STEP;
        end else begin
          d_q[NS+i+1] <= d_q[NS+i] - dxs;
          n_q[NS+i+1] <= n_q[NS+i] + dys;
          a_q[NS+i+1] <= a_q[NS+i] - STEP;
        end
        z_q[NS+i+1] <= z_q[NS+i];
      end
    end
  end

  // round half up to 1/128 degree and saturate at a half turn
  always_comb begin
    rnd = (a_q[L] + RND) >>> 8;
    sat = rnd;
    if (rnd > SAT_HI) sat = SAT_HI;
    else if (rnd < -SAT_HI) sat = -SAT_HI;
  end

  always_ff @(posedge clk) begin
    if (en) angle <= z_q[L] ? '0 : q2e_pkg::ANG_W'(sat);
  end

endmodule

// ===== rtl/quaternion_to_euler.sv =====
// quaternion to euler angle converter, top level
// depends on q2e_pkg, q2e_front, q2e_fifo, q2e_isqrt and q2e_atan2
//
// usage:
//   s_axis carries one quaternion request per transfer, tdata = {z, y, x, w},
//   each signed q1.15, w in the lowest bits. m_axis returns one result per
//   request in the same order: roll, pitch and yaw in 1/128 degree plus a flag
//   set when the asin argument had to be clamped to unit range.
// stages: 2 front stages, 1 queue slot, 33 square-root stages, 8 + 16
//   atan2 stages (fold, normalise, rounding and one per cordic step) and
//   the output register.
// throughput: one request per cycle when not stalled; every stage is fully
//   pipelined, and square root and cordic give one bit or one rotation per stage.
// stalls: when m_axis_tready is low while a result is presented, the back
//   pipeline and output register hold; the front keeps accepting until the
//   4-entry queue fills, then s_axis_tready drops.
// reset: rst is synchronous and active high; it empties the queue and clears
//   every stage valid, so no result is presented until new requests arrive.
module quaternion_to_euler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [15:0] quat_w, [31:16] quat_x, [47:32] quat_y, [63:48] quat_z
  input  logic [63:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] roll_angle, [30:16] pitch_angle, [46:31] yaw_angle, [47] pitch_clamped
  output logic [47:0] m_axis_tdata
);

  localparam int QW  = q2e_pkg::QUAT_W;
  localparam int VW  = q2e_pkg::VEC_W;
  localparam int AGW = q2e_pkg::ANG_W;
  localparam int PW  = q2e_pkg::PITCH_W;
  localparam int IL  = q2e_pkg::ISQ_LAT;
  localparam int TL  = q2e_pkg::ATAN_LAT;
  localparam int BL  = q2e_pkg::BACK_LAT;
  localparam logic signed [AGW-1:0] P_HI = AGW'(q2e_pkg::PITCH_MAX);

  logic                    push;
  logic                    pop;
  logic                    back_en;
  q2e_pkg::q2e_item_t      push_item;
  q2e_pkg::q2e_item_t      pop_item;
  q2e_pkg::q2e_fifo_stat_t stat;

  logic [BL-1:0]           vld;
  q2e_pkg::q2e_item_t      d_q [0:IL-1];
  q2e_pkg::q2e_flags_t     f_q [0:TL-1];
  q2e_pkg::q2e_flags_t     f_in;

  logic [q2e_pkg::ROOT_W-1:0] root;
  logic signed [AGW-1:0] roll_a, yaw_a, pitch_a;
  logic signed [AGW-1:0] pitch_fix;

  logic            out_valid;
  logic [AGW-1:0]  roll_r, yaw_r;
  logic [PW-1:0]   pitch_r;
  logic            clamp_r;

  // front end
  q2e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .quat_w   (s_axis_tdata[QW-1:0]),
    .quat_x   (s_axis_tdata[2*QW-1:QW]),
    .quat_y   (s_axis_tdata[3*QW-1:2*QW]),
    .quat_z   (s_axis_tdata[4*QW-1:3*QW]),
    .stat     (stat),
    .push     (push),
    .item     (push_item)
  );

  // decoupling queue
  q2e_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .stat      (stat)
  );

  // back pipeline advances whenever the output register can take a result
  assign back_en = !out_valid || m_axis_tready;
  assign pop     = back_en && !stat.empty;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (back_en) vld <= {vld[BL-2:0], pop};
  end

  // cosine term for the pitch asin
  q2e_isqrt u_isqrt (
    .clk  (clk),
    .en   (back_en),
    .arg  (pop_item.pitch_arg),
    .root (root)
  );

  // roll and yaw operands wait beside the square root
  always_ff @(posedge clk) begin
    if (back_en) d_q[0] <= pop_item;
  end
  for (genvar k = 1; k < IL; k++) begin : g_dly
    always_ff @(posedge clk) begin
      if (back_en) d_q[k] <= d_q[k-1];
    end
  end

  // three angle units in lockstep
  q2e_atan2 u_roll (
    .clk   (clk),
    .en    (back_en),
    .num   (d_q[IL-1].roll_num),
    .den   (d_q[IL-1].roll_den),
    .angle (roll_a)
  );

  q2e_atan2 u_yaw (
    .clk   (clk),
    .en    (back_en),
    .num   (d_q[IL-1].yaw_num),
    .den   (d_q[IL-1].yaw_den),
    .angle (yaw_a)
  );

  q2e_atan2 u_pitch (
    .clk   (clk),
    .en    (back_en),
    .num   (VW'(d_q[IL-1].pitch_arg)),
    .den   (VW'(root)),
    .angle (pitch_a)
  );

  // pitch flags ride along the cordic
  assign f_in.clamped  = d_q[IL-1].pitch_clamped;
  assign f_in.edge_hit = d_q[IL-1].pitch_edge;
  assign f_in.neg      = d_q[IL-1].pitch_arg[q2e_pkg::ARG_W-1];

  always_ff @(posedge clk) begin
    if (back_en) f_q[0] <= f_in;
  end
  for (genvar k = 1; k < TL; k++) begin : g_flag
    always_ff @(posedge clk) begin
      if (back_en) f_q[k] <= f_q[k-1];
    end
  end

  // exact quarter turn at the unit edge, otherwise limit to a quarter turn
  always_comb begin
    if (f_q[TL-1].edge_hit) pitch_fix = f_q[TL-1].neg ? -P_HI : P_HI;
    else if (pitch_a > P_HI) pitch_fix = P_HI;
    else if (pitch_a < -P_HI) pitch_fix = -P_HI;
    else pitch_fix = pitch_a;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (back_en) out_valid <= vld[BL-1];
  end

  always_ff @(posedge clk) begin
    if (back_en) begin
      roll_r  <= roll_a;
      yaw_r   <= yaw_a;
      pitch_r <= pitch_fix[PW-1:0];
      clamp_r <= f_q[TL-1].clamped;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {clamp_r, yaw_r, pitch_r, roll_r};

`ifndef SYNTH
  a_clamp_sat: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[47]) |->
      (m_axis_tdata[30:16] == PW'(q2e_pkg::PITCH_MAX) ||
       m_axis_tdata[30:16] == PW'(-q2e_pkg::PITCH_MAX)))
    else $error("clamped pitch not at a quarter turn");
  a_hold_stall: assert property (@(posedge clk) disable iff (rst)
    !back_en |=> $stable(vld)) else $error("back pipeline moved while stalled");
  a_ready_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> stat.full) else $error("front stalled with queue room");
`endif

endmodule
